// ===== rtl/core/dtsg_pkg.sv =====
`default_nettype none
package dtsg_pkg;

	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned COEF_W     = 16;
	localparam int unsigned Q_W        = 40;
	localparam int unsigned P_W        = 42;
	localparam int unsigned MB_W       = 17;
	localparam int unsigned MP_W       = P_W + MB_W;
	localparam int unsigned ACC_W      = 84;
	localparam int unsigned ENERGY_W   = 48;
	localparam int unsigned COEF_FRAC  = 14;
	localparam int unsigned ENERGY_SH  = 16;
	localparam int unsigned CHUNK_BITS = 16;
	localparam int unsigned WLEN_W     = 8;
	localparam int unsigned SUB_W      = 4;

	localparam logic [SUB_W-1:0] ENG_LAST_SUB = 4'd10;

	localparam logic [COEF_W-1:0] MARK_COEF_RST  = 16'd31557;
	localparam logic [COEF_W-1:0] SPACE_COEF_RST = 16'd32085;
	localparam logic [WLEN_W-1:0] WLEN_RST       = 8'd92;

	localparam logic [1:0] REG_MARK   = 2'd0;
	localparam logic [1:0] REG_SPACE  = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_REC   = 5'b00010,
		ST_ENG   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_REC,
		OP_P,
		OP_ACC,
		OP_DONE
	} op_kind_t;

	typedef enum logic [1:0] {
		SRC_Q1,
		SRC_Q2,
		SRC_P
	} src_t;

	typedef enum logic [1:0] {
		CHUNK_LO,
		CHUNK_MID,
		CHUNK_HI
	} chunk_t;

	typedef struct packed {
		op_kind_t kind;
		logic     tone;
		logic     first;
		logic     neg;
		src_t     a_src;
		src_t     b_src;
		chunk_t   chunk;
	} mac_op_t;

endpackage
`default_nettype wire

// ===== rtl/core/dual_tone_sliding_goertzel_unit.sv =====
// Dual-tone sliding Goertzel unit.
// Samples enter on sample_valid/sample_ready with a restart flag; each accepted
// item is written into a ring of the newest WINDOW_MAX samples. Once the ring
// holds L samples (window_length clamped to 2..WINDOW_MAX), each item yields
// one result on result_valid/result_ready: the mark and space tone energies of
// the L newest samples.
// One 42x17 multiplier is shared by both tones and all steps: the recurrence
// uses it twice per window sample, tones interleaved, then 11 steps per tone
// form the energy from partial products over slices of at most 16 bits.
// An item that yields a result holds sample_ready low through the recurrence,
// the energy steps, a drain state and the output state, until its result is
// loaded into the output register; an item that yields no result leaves it high.
// The result sits in an output register; if the receiver stalls, the next
// finished result waits in the unit and sample_ready stays low until the
// output register frees up.
// Reset empties the ring and restores mark 31557, space 32085, window 92.
// APB registers: 0x0 mark coefficient, 0x4 space coefficient, 0x8 window length.
`default_nettype none
module dual_tone_sliding_goertzel_unit import dtsg_pkg::*; #(
	parameter int unsigned WINDOW_MAX = 128
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [3:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  wire logic                       sample_valid,
	output logic                            sample_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic                       restart,
	output logic                            result_valid,
	input  wire logic                       result_ready,
	output logic [ENERGY_W-1:0]             mark_power,
	output logic [ENERGY_W-1:0]             space_power
);

	localparam int unsigned LW = $clog2(WINDOW_MAX + 1);

	logic [COEF_W-1:0]   mark_coef_q, space_coef_q;
	logic [WLEN_W-1:0]   wlen_q;
	logic [LW-1:0]       len_c;
	logic                sample_accept, produce, rd_en, out_load;
	logic [SAMPLE_W-1:0] rdata;
	logic [ENERGY_W-1:0] mark_eng, space_eng;
	logic [ENERGY_W-1:0] mark_power_q, space_power_q;
	logic                result_valid_q;
	mac_op_t             op;

	assign pready        = 1'b1;
	assign sample_accept = sample_valid && sample_ready;

	always_comb begin
		if (wlen_q < WLEN_W'(2)) begin
			len_c = LW'(2);
		end else if (32'(wlen_q) > WINDOW_MAX) begin
			len_c = LW'(WINDOW_MAX);
		end else begin
			len_c = LW'(wlen_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_coef_q  <= MARK_COEF_RST;
			space_coef_q <= SPACE_COEF_RST;
			wlen_q       <= WLEN_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_MARK:   mark_coef_q  <= pwdata[COEF_W-1:0];
				REG_SPACE:  space_coef_q <= pwdata[COEF_W-1:0];
				REG_WINDOW: wlen_q       <= pwdata[WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MARK:   prdata = 32'(mark_coef_q);
			REG_SPACE:  prdata = 32'(space_coef_q);
			REG_WINDOW: prdata = 32'(wlen_q);
			default:    prdata = '0;
		endcase
	end

	dtsg_ring #(.WINDOW_MAX(WINDOW_MAX)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (sample_accept),
		.sample  (sample),
		.restart (restart),
		.len     (len_c),
		.rd_en   (rd_en),
		.produce (produce),
		.rdata   (rdata)
	);

	dtsg_ctrl #(.WINDOW_MAX(WINDOW_MAX)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_accept (sample_accept),
		.produce       (produce),
		.len           (len_c),
		.result_valid  (result_valid_q),
		.result_ready  (result_ready),
		.sample_ready  (sample_ready),
		.rd_en         (rd_en),
		.out_load      (out_load),
		.op            (op)
	);

	dtsg_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.rdata      (rdata),
		.coef_mark  (mark_coef_q),
		.coef_space (space_coef_q),
		.mark_eng   (mark_eng),
		.space_eng  (space_eng)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mark_power_q  <= mark_eng;
			space_power_q <= space_eng;
		end
	end

	assign result_valid = result_valid_q;
	assign mark_power   = mark_power_q;
	assign space_power  = space_power_q;

endmodule
`default_nettype wire

// ===== rtl/core/dtsg_ring.sv =====
`default_nettype none
module dtsg_ring import dtsg_pkg::*; #(
	parameter int unsigned WINDOW_MAX = 128,
	localparam int unsigned AW = $clog2(WINDOW_MAX),
	localparam int unsigned LW = $clog2(WINDOW_MAX + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                restart,
	input  wire logic [LW-1:0]       len,
	input  wire logic                rd_en,
	output logic                     produce,
	output logic [SAMPLE_W-1:0]      rdata
);

	localparam int unsigned SW = LW + 1;

	logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
	logic [SAMPLE_W-1:0] rdata_q;
	logic [AW-1:0]       wpos_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [LW-1:0]       fill_q;
	logic [AW-1:0]       base_pos;
	logic [AW-1:0]       next_pos;
	logic [LW-1:0]       base_fill;
	logic [LW-1:0]       next_fill;
	logic [SW-1:0]       np_ext;
	logic [SW-1:0]       len_ext;
	logic [SW-1:0]       start_ext;

	always_comb begin
		base_pos  = restart ? '0 : wpos_q;
		base_fill = restart ? '0 : fill_q;
		next_pos  = (base_pos == AW'(WINDOW_MAX - 1)) ? '0 : base_pos + AW'(1);
		next_fill = (base_fill == LW'(WINDOW_MAX)) ? base_fill : base_fill + LW'(1);
		produce   = (next_fill >= len);
		np_ext    = SW'(next_pos);
		len_ext   = SW'(len);
		start_ext = (np_ext >= len_ext) ? np_ext - len_ext
		                                : np_ext + SW'(WINDOW_MAX) - len_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q   <= '0;
			fill_q   <= '0;
			rd_ptr_q <= '0;
		end else if (wr_en) begin
			wpos_q   <= next_pos;
			fill_q   <= next_fill;
			rd_ptr_q <= start_ext[AW-1:0];
		end else if (rd_en) begin
			rd_ptr_q <= (rd_ptr_q == AW'(WINDOW_MAX - 1)) ? '0 : rd_ptr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[base_pos] <= sample;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/dtsg_mac.sv =====
`default_nettype none
module dtsg_mac import dtsg_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mac_op_t             op,
	input  wire logic [SAMPLE_W-1:0] rdata,
	input  wire logic [COEF_W-1:0]   coef_mark,
	input  wire logic [COEF_W-1:0]   coef_space,
	output logic [ENERGY_W-1:0]      mark_eng,
	output logic [ENERGY_W-1:0]      space_eng
);

	function automatic logic signed [MB_W-1:0] chunk_of(logic [Q_W-1:0] v, chunk_t c);
		logic signed [MB_W-1:0] r;
		unique case (c)
			CHUNK_LO:  r = {1'b0, v[CHUNK_BITS-1:0]};
			CHUNK_MID: r = {1'b0, v[2*CHUNK_BITS-1:CHUNK_BITS]};
			CHUNK_HI:  r = {{(MB_W-(Q_W-2*CHUNK_BITS)){v[Q_W-1]}}, v[Q_W-1:2*CHUNK_BITS]};
			default:   r = '0;
		endcase
		return r;
	endfunction

	logic [Q_W-1:0]           q1_mark_q, q2_mark_q, q1_space_q, q2_space_q;
	logic [P_W-1:0]           p_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ENERGY_W-1:0]      mark_eng_q, space_eng_q;
	mac_op_t                  op_s1;
	logic signed [MP_W-1:0]   prod_s1;

	logic [Q_W-1:0]           q1_sel, q2_sel, b_val;
	logic [COEF_W-1:0]        coef_sel;
	logic signed [P_W-1:0]    a_mul;
	logic signed [MB_W-1:0]   b_mul;
	logic signed [MP_W-1:0]   mul_w;

	logic [Q_W-1:0]           q1_s2, q2_s2, q2_eff, p_rec, x_ext, q0;
	logic signed [ACC_W-1:0]  term_w, term_sh, acc_base, acc_next;
	logic [ENERGY_W-1:0]      eng_clamp;

	always_comb begin
		q1_sel   = op.tone ? q1_space_q : q1_mark_q;
		q2_sel   = op.tone ? q2_space_q : q2_mark_q;
		coef_sel = op.tone ? coef_space : coef_mark;
		b_val    = (op.b_src == SRC_Q2) ? q2_sel : q1_sel;
		a_mul    = '0;
		b_mul    = '0;
		case (op.kind) inside
			OP_REC, OP_P: begin
				if (!(op.kind == OP_REC && op.first)) begin
					a_mul = {{(P_W-Q_W){q1_sel[Q_W-1]}}, q1_sel};
				end
				b_mul = {coef_sel[COEF_W-1], coef_sel};
			end
			OP_ACC: begin
				case (op.a_src)
					SRC_Q1:  a_mul = {{(P_W-Q_W){q1_sel[Q_W-1]}}, q1_sel};
					SRC_Q2:  a_mul = {{(P_W-Q_W){q2_sel[Q_W-1]}}, q2_sel};
					SRC_P:   a_mul = p_q;
					default: a_mul = '0;
				endcase
				b_mul = chunk_of(b_val, op.chunk);
			end
			default: ;
		endcase
	end

	assign mul_w = a_mul * b_mul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_w;
	end

	always_comb begin
		q1_s2    = op_s1.tone ? q1_space_q : q1_mark_q;
		q2_s2    = op_s1.tone ? q2_space_q : q2_mark_q;
		q2_eff   = op_s1.first ? '0 : q2_s2;
		p_rec    = prod_s1[COEF_FRAC+Q_W-1:COEF_FRAC];
		x_ext    = {{(Q_W-SAMPLE_W){rdata[SAMPLE_W-1]}}, rdata};
		q0       = p_rec - q2_eff + x_ext;
		term_w   = {{(ACC_W-MP_W){prod_s1[MP_W-1]}}, prod_s1};
		case (op_s1.chunk)
			CHUNK_MID: term_sh = term_w <<< CHUNK_BITS;
			CHUNK_HI:  term_sh = term_w <<< (2 * CHUNK_BITS);
			default:   term_sh = term_w;
		endcase
		acc_base = op_s1.first ? '0 : acc_q;
		acc_next = op_s1.neg ? acc_base - term_sh : acc_base + term_sh;
		if (acc_q[ACC_W-1]) begin
			eng_clamp = '0;
		end else if (|acc_q[ACC_W-2:ENERGY_W+ENERGY_SH]) begin
			eng_clamp = '1;
		end else begin
			eng_clamp = acc_q[ENERGY_W+ENERGY_SH-1:ENERGY_SH];
		end
	end

	always_ff @(posedge clk) begin
		case (op_s1.kind)
			OP_REC: begin
				if (op_s1.tone) begin
					q2_space_q <= op_s1.first ? '0 : q1_s2;
					q1_space_q <= q0;
				end else begin
					q2_mark_q <= op_s1.first ? '0 : q1_s2;
					q1_mark_q <= q0;
				end
			end
			OP_P:   p_q   <= prod_s1[COEF_FRAC+P_W-1:COEF_FRAC];
			OP_ACC: acc_q <= acc_next;
			OP_DONE: begin
				if (op_s1.tone) begin
					space_eng_q <= eng_clamp;
				end else begin
					mark_eng_q <= eng_clamp;
				end
			end
			default: ;
		endcase
	end

	assign mark_eng  = mark_eng_q;
	assign space_eng = space_eng_q;

endmodule
`default_nettype wire

// ===== rtl/core/dtsg_ctrl.sv =====
`default_nettype none
module dtsg_ctrl import dtsg_pkg::*; #(
	parameter int unsigned WINDOW_MAX = 128,
	localparam int unsigned LW = $clog2(WINDOW_MAX + 1),
	localparam int unsigned CW = $clog2(2 * WINDOW_MAX)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sample_accept,
	input  wire logic          produce,
	input  wire logic [LW-1:0] len,
	input  wire logic          result_valid,
	input  wire logic          result_ready,
	output logic               sample_ready,
	output logic               rd_en,
	output logic               out_load,
	output mac_op_t            op
);

	state_t           state_q;
	logic [CW-1:0]    cnt_q;
	logic [LW-1:0]    len_q;
	logic             tone_q;
	logic [SUB_W-1:0] sub_q;
	logic [CW-1:0]    last_cnt;

	assign last_cnt     = CW'({len_q, 1'b0} - (LW + 1)'(1));
	assign sample_ready = (state_q == ST_IDLE);
	assign out_load     = (state_q == ST_OUT) && (!result_valid || result_ready);

	always_comb begin
		op    = '0;
		rd_en = 1'b0;
		unique case (state_q)
			ST_REC: begin
				op.kind  = OP_REC;
				op.tone  = cnt_q[0];
				op.first = (cnt_q[CW-1:1] == '0);
				rd_en    = !cnt_q[0];
			end
			ST_ENG: begin
				op.tone = tone_q;
				unique case (sub_q)
					4'd0: op.kind = OP_P;
					4'd1, 4'd2, 4'd3: begin
						op.kind  = OP_ACC;
						op.a_src = SRC_Q1;
						op.b_src = SRC_Q1;
						op.first = (sub_q == 4'd1);
					end
					4'd4, 4'd5, 4'd6: begin
						op.kind  = OP_ACC;
						op.a_src = SRC_Q2;
						op.b_src = SRC_Q2;
					end
					4'd7, 4'd8, 4'd9: begin
						op.kind  = OP_ACC;
						op.a_src = SRC_P;
						op.b_src = SRC_Q2;
						op.neg   = 1'b1;
					end
					ENG_LAST_SUB: op.kind = OP_DONE;
					default: ;
				endcase
				unique case (sub_q)
					4'd1, 4'd4, 4'd7: op.chunk = CHUNK_LO;
					4'd2, 4'd5, 4'd8: op.chunk = CHUNK_MID;
					4'd3, 4'd6, 4'd9: op.chunk = CHUNK_HI;
					default:          op.chunk = CHUNK_LO;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			len_q   <= '0;
			tone_q  <= 1'b0;
			sub_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sample_accept && produce) begin
						state_q <= ST_REC;
						cnt_q   <= '0;
						len_q   <= len;
					end
				end
				ST_REC: begin
					if (cnt_q == last_cnt) begin
						state_q <= ST_ENG;
						tone_q  <= 1'b0;
						sub_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_ENG: begin
					if (sub_q == ENG_LAST_SUB) begin
						sub_q <= '0;
						if (tone_q) begin
							state_q <= ST_DRAIN;
						end else begin
							tone_q <= 1'b1;
						end
					end else begin
						sub_q <= sub_q + SUB_W'(1);
					end
				end
				ST_DRAIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/dtsg_port_checker.sv =====
`default_nettype none
module dtsg_port_checker import dtsg_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                sample_valid,
	input wire logic                sample_ready,
	input wire logic                restart,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire logic [ENERGY_W-1:0] mark_power,
	input wire logic [ENERGY_W-1:0] space_power
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(mark_power) && $stable(space_power))
		else $error("stalled result changed");

	a_restart_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && restart |=> sample_ready)
		else $error("restart item started a computation");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_ready))
		else $error("result appeared without a busy phase");

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_ready) |-> $past(sample_valid && sample_ready))
		else $error("busy without an accepted item");

endmodule

bind dual_tone_sliding_goertzel_unit dtsg_port_checker u_port_checker (.*);
`default_nettype wire
